// ===== hdl/irsr_pkg.sv =====
// Shared types, register codes and constants of the IR SIRC/RC5 frame decoder.
package irsr_pkg;

	localparam int MAX_DURATIONS_DEF = 64;
	localparam int QUEUE_DEPTH       = 2;
	localparam int COUNT_W           = 7;
	localparam int SIRC_BITS_W       = 12;
	localparam int RC5_BITS_W        = 14;
	localparam int SIRC_FRAME_LEN    = 25;
	localparam int CFG_INDEX_W       = 4;

	// item function codes
	localparam logic [1:0] FUNC_DURATION = 2'd0;
	localparam logic [1:0] FUNC_END      = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_PROTO = 2'd1;
	localparam logic [1:0] ST_TOO_MANY = 2'd2;
	localparam logic [1:0] ST_TIMEOUT  = 2'd3;

	localparam logic PROTO_SIRC = 1'b0;
	localparam logic PROTO_RC5  = 1'b1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SIRC_START  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIRC_SPACE  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SIRC_ONE    = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SIRC_ZERO   = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_RC5_HALF    = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_RC5_FULL    = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SIRC_REPEAT = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_RC5_REPEAT  = 4'd7;

	// register reset values
	localparam logic [15:0] RST_SIRC_START  = 16'd2400;
	localparam logic [15:0] RST_SIRC_SPACE  = 16'd600;
	localparam logic [15:0] RST_SIRC_ONE    = 16'd1200;
	localparam logic [15:0] RST_SIRC_ZERO   = 16'd600;
	localparam logic [15:0] RST_RC5_HALF    = 16'd889;
	localparam logic [15:0] RST_RC5_FULL    = 16'd1778;
	localparam logic [15:0] RST_SIRC_REPEAT = 16'd45;
	localparam logic [15:0] RST_RC5_REPEAT  = 16'd114;

	typedef struct packed {
		logic [15:0] sirc_start_time;
		logic [15:0] sirc_space_time;
		logic [15:0] sirc_one_time;
		logic [15:0] sirc_zero_time;
		logic [15:0] rc5_half_time;
		logic [15:0] rc5_full_time;
		logic [15:0] sirc_repeat_ms;
		logic [15:0] rc5_repeat_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] duration;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        protocol;
		logic [4:0]  address;
		logic [6:0]  command;
		logic [15:0] repeat_time;
	} result_t;

	// window checks of one duration against every nominal time
	typedef struct packed {
		logic start_ok;
		logic space_ok;
		logic one_ok;
		logic zero_ok;
		logic half_ok;
		logic full_ok;
	} class_t;

	typedef struct packed {
		logic [1:0] func;
		class_t     cls;
	} entry_t;

endpackage

// ===== hdl/irsr_front.sv =====
// Front end: classifies one duration against all tolerance windows.
module irsr_front (
	input  irsr_pkg::cfg_t   cfg,
	input  irsr_pkg::item_t  item,
	output irsr_pkg::entry_t entry
);

	// nom / 5, exact for any 16-bit value
	function automatic logic [13:0] fifth(input logic [15:0] nom);
		logic [31:0] p;
		p = 32'(nom) * 32'd52429;
		return p[31:18];
	endfunction

	function automatic logic in_incl(input logic [15:0] d, input logic [15:0] nom);
		logic [13:0] f;
		logic [16:0] hi;
		logic [15:0] lo;
		f  = fifth(nom);
		hi = {1'b0, nom} + {3'b000, f};
		lo = nom - {2'b00, f};
		return ({1'b0, d} <= hi) && (d >= lo);
	endfunction

	function automatic logic in_strict(input logic [15:0] d, input logic [15:0] nom);
		logic [13:0] f;
		logic [16:0] hi;
		logic [15:0] lo;
		f  = fifth(nom);
		hi = {1'b0, nom} + {3'b000, f};
		lo = nom - {2'b00, f};
		return ({1'b0, d} < hi) && (d > lo);
	endfunction

	always_comb begin
		entry.func         = item.func;
		entry.cls.start_ok = in_incl(item.duration, cfg.sirc_start_time);
		entry.cls.space_ok = in_incl(item.duration, cfg.sirc_space_time);
		entry.cls.one_ok   = in_strict(item.duration, cfg.sirc_one_time);
		entry.cls.zero_ok  = in_strict(item.duration, cfg.sirc_zero_time);
		entry.cls.half_ok  = in_strict(item.duration, cfg.rc5_half_time);
		entry.cls.full_ok  = in_strict(item.duration, cfg.rc5_full_time);
	end

endmodule

// ===== hdl/irsr_queue.sv =====
// Short queue of classified transactions between front and back end.
module irsr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  irsr_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output irsr_pkg::entry_t head
);

	localparam int DEPTH = irsr_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	irsr_pkg::entry_t slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/irsr_back.sv =====
// Back end: frame state of both protocols and the result register.
module irsr_back #(
	parameter int MAX_DURATIONS = irsr_pkg::MAX_DURATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  irsr_pkg::cfg_t     cfg,
	input  logic               q_valid,
	input  irsr_pkg::entry_t   q_entry,
	output logic               q_pop,
	output logic               result_valid,
	input  logic               result_ready,
	output irsr_pkg::result_t  result
);

	localparam int CW = irsr_pkg::COUNT_W;
	localparam logic [CW-1:0] LIMIT    = CW'(MAX_DURATIONS - 1);
	localparam logic [CW-1:0] SIRC_LEN = CW'(irsr_pkg::SIRC_FRAME_LEN);
	localparam int SB = irsr_pkg::SIRC_BITS_W;
	localparam int RB = irsr_pkg::RC5_BITS_W;

	logic [CW-1:0] item_count_q;
	logic          sirc_good_q;
	logic [SB-1:0] sirc_bits_q;
	logic          rc5_good_q;
	logic [6:0]    rc5_half_count_q;
	logic [RB-1:0] rc5_bits_q;

	logic              out_valid_q;
	irsr_pkg::result_t out_q;

	logic [CW-1:0] count_n;
	logic          sirc_good_n;
	logic [SB-1:0] sirc_bits_n;
	logic          rc5_good_n;
	logic [6:0]    rc5_half_n;
	logic [RB-1:0] rc5_bits_n;
	logic          emit;
	logic          clear;
	irsr_pkg::result_t res;

	logic [5:0] sirc_idx;
	logic [5:0] rc5_pos;
	logic [7:0] half_sum;
	logic [6:0] rc5_hi;

	assign q_pop        = q_valid && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		count_n     = item_count_q;
		sirc_good_n = sirc_good_q;
		sirc_bits_n = sirc_bits_q;
		rc5_good_n  = rc5_good_q;
		rc5_half_n  = rc5_half_count_q;
		rc5_bits_n  = rc5_bits_q;
		emit        = 1'b0;
		clear       = 1'b0;
		res         = '0;
		sirc_idx    = item_count_q[CW-1:1] - 6'd1;
		rc5_pos     = rc5_half_count_q[6:1];
		half_sum    = '0;
		rc5_hi      = rc5_bits_q[12:6];

		case (q_entry.func)
			irsr_pkg::FUNC_DURATION: begin
				// SIRC: start mark, spaces, then bit marks at even positions
				if (sirc_good_q) begin
					if (item_count_q == '0) begin
						sirc_good_n = q_entry.cls.start_ok;
					end else if (item_count_q[0]) begin
						sirc_good_n = q_entry.cls.space_ok;
					end else if (q_entry.cls.one_ok) begin
						for (int j = 0; j < SB; j++) begin
							if (sirc_idx == 6'(j)) begin
								sirc_bits_n[j] = 1'b1;
							end
						end
					end else if (!q_entry.cls.zero_ok) begin
						sirc_good_n = 1'b0;
					end
				end
				// RC5: count half bits, sample at mark boundaries
				if (rc5_good_q) begin
					if (rc5_half_count_q[0] && !item_count_q[0]) begin
						for (int j = 0; j < RB; j++) begin
							if (rc5_pos == 6'(RB - 1 - j)) begin
								rc5_bits_n[j] = 1'b1;
							end
						end
					end
					if (q_entry.cls.half_ok) begin
						half_sum = {1'b0, rc5_half_count_q} + 8'd1;
					end else if (q_entry.cls.full_ok) begin
						half_sum = {1'b0, rc5_half_count_q} + 8'd2;
					end else begin
						half_sum   = {1'b0, rc5_half_count_q};
						rc5_good_n = 1'b0;
					end
					rc5_half_n = half_sum[7] ? 7'h7f : half_sum[6:0];
				end
				count_n = item_count_q + 1'b1;
				if (count_n >= LIMIT) begin
					emit       = 1'b1;
					clear      = 1'b1;
					res.status = irsr_pkg::ST_TOO_MANY;
				end
			end
			irsr_pkg::FUNC_TIMEOUT: begin
				emit       = 1'b1;
				clear      = 1'b1;
				res.status = irsr_pkg::ST_TIMEOUT;
			end
			irsr_pkg::FUNC_END: begin
				emit  = 1'b1;
				clear = 1'b1;
				if (sirc_good_q && item_count_q == SIRC_LEN) begin
					res.status      = irsr_pkg::ST_OK;
					res.protocol    = irsr_pkg::PROTO_SIRC;
					res.address     = sirc_bits_q[11:7];
					res.command     = sirc_bits_q[6:0];
					res.repeat_time = cfg.sirc_repeat_ms;
				end else if (rc5_good_q) begin
					res.status      = irsr_pkg::ST_OK;
					res.protocol    = irsr_pkg::PROTO_RC5;
					res.address     = rc5_hi[4:0];
					res.command     = {~rc5_hi[6], rc5_bits_q[5:0]};
					res.repeat_time = cfg.rc5_repeat_ms;
				end else begin
					res.status = irsr_pkg::ST_NO_PROTO;
				end
			end
			default: begin
				// unused code: drop silently
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q      <= 1'b0;
			item_count_q     <= '0;
			sirc_good_q      <= 1'b1;
			sirc_bits_q      <= '0;
			rc5_good_q       <= 1'b1;
			rc5_half_count_q <= 7'd1;
			rc5_bits_q       <= '0;
		end else begin
			if (q_pop) begin
				out_valid_q <= emit;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (clear) begin
					item_count_q     <= '0;
					sirc_good_q      <= 1'b1;
					sirc_bits_q      <= '0;
					rc5_good_q       <= 1'b1;
					rc5_half_count_q <= 7'd1;
					rc5_bits_q       <= '0;
				end else begin
					item_count_q     <= count_n;
					sirc_good_q      <= sirc_good_n;
					sirc_bits_q      <= sirc_bits_n;
					rc5_good_q       <= rc5_good_n;
					rc5_half_count_q <= rc5_half_n;
					rc5_bits_q       <= rc5_bits_n;
				end
			end
		end
	end

endmodule

// ===== hdl/ir_sirc_rc5_frame_decoder_unit.sv =====
// Top level of the IR SIRC/RC5 frame decoder: registers, front end, queue, back end.
//
// Feed measured IR durations on the item channel (item_valid/item_ready, payload
// item): mark, space, mark, ... each with func set to duration, then one frame-end
// or mark-timeout transaction. SIRC (12 bit) and RC5 are checked in parallel.
// Each frame end, mark timeout or overlong frame yields one transaction on the
// result channel (result_valid/result_ready, payload result) carrying status,
// protocol, address, command and repeat time. Plain durations yield nothing.
//
// Write the eight timing registers through cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high, indexes beyond seven are dropped.
// Write them only while the decoder is idle.
//
// Items are queued and results are registered. Throughput is one item per cycle
// unless the receiver stalls: the front end classifies a duration in the cycle it
// is accepted and the back end retires one queued transaction per cycle.
// When the receiver stalls, the result register holds and the two-entry queue
// fills; item_ready falls once the queue is full.
// Reset restores the register defaults, empties the queue and starts a new frame.
module ir_sirc_rc5_frame_decoder_unit #(
	parameter int MAX_DURATIONS = irsr_pkg::MAX_DURATIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  irsr_pkg::item_t                    item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output irsr_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [irsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [15:0]                        cfg_data
);

	irsr_pkg::cfg_t   cfg_q;
	irsr_pkg::entry_t front_entry;
	irsr_pkg::entry_t head;
	logic             q_full;
	logic             q_not_empty;
	logic             q_pop;

	assign cfg_ready  = 1'b1;
	assign item_ready = !q_full;

	// Register file: hold values, advance only on a write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sirc_start_time <= irsr_pkg::RST_SIRC_START;
			cfg_q.sirc_space_time <= irsr_pkg::RST_SIRC_SPACE;
			cfg_q.sirc_one_time   <= irsr_pkg::RST_SIRC_ONE;
			cfg_q.sirc_zero_time  <= irsr_pkg::RST_SIRC_ZERO;
			cfg_q.rc5_half_time   <= irsr_pkg::RST_RC5_HALF;
			cfg_q.rc5_full_time   <= irsr_pkg::RST_RC5_FULL;
			cfg_q.sirc_repeat_ms  <= irsr_pkg::RST_SIRC_REPEAT;
			cfg_q.rc5_repeat_ms   <= irsr_pkg::RST_RC5_REPEAT;
		end else if (cfg_valid) begin
			case (cfg_index)
				irsr_pkg::REG_SIRC_START: begin
					cfg_q.sirc_start_time <= cfg_data;
				end
				irsr_pkg::REG_SIRC_SPACE: begin
					cfg_q.sirc_space_time <= cfg_data;
				end
				irsr_pkg::REG_SIRC_ONE: begin
					cfg_q.sirc_one_time <= cfg_data;
				end
				irsr_pkg::REG_SIRC_ZERO: begin
					cfg_q.sirc_zero_time <= cfg_data;
				end
				irsr_pkg::REG_RC5_HALF: begin
					cfg_q.rc5_half_time <= cfg_data;
				end
				irsr_pkg::REG_RC5_FULL: begin
					cfg_q.rc5_full_time <= cfg_data;
				end
				irsr_pkg::REG_SIRC_REPEAT: begin
					cfg_q.sirc_repeat_ms <= cfg_data;
				end
				irsr_pkg::REG_RC5_REPEAT: begin
					cfg_q.rc5_repeat_ms <= cfg_data;
				end
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// Front end: window compares on the incoming duration
	irsr_front u_front (
		.cfg   (cfg_q),
		.item  (item),
		.entry (front_entry)
	);

	// Queue decouples classification from frame tracking
	irsr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (item_valid),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	// Back end: protocol state and result register
	irsr_back #(
		.MAX_DURATIONS (MAX_DURATIONS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_not_empty),
		.q_entry      (head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== test/ir_sirc_rc5_frame_decoder_unit_test.sv =====
// Self-checking testbench of the IR SIRC/RC5 frame decoder: random frames against a predictor.
module ir_sirc_rc5_frame_decoder_unit_test;

	// Function code 3 has no meaning; the decoder drops such transactions.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;

	typedef enum {TIMING_WOBBLE, TIMING_EDGE_IN, TIMING_EDGE_OUT} timing_style_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	irsr_pkg::item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	irsr_pkg::result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [irsr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	ir_sirc_rc5_frame_decoder_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Own copy of the timing registers, indexed by register code.
	logic [15:0] timing [16];

	// Frame state as the decoder should hold it.
	logic [6:0]  frame_len;
	logic        sirc_alive;
	logic [11:0] sirc_word;
	logic        rc5_alive;
	logic [6:0]  rc5_halves;
	logic [13:0] rc5_word;

	irsr_pkg::result_t frame_reports [$];   // reports still owed by the decoder, oldest first
	irsr_pkg::result_t oldest;
	int unsigned items_fed = 0;       // accepted transactions other than dropped ones
	int unsigned reports_due = 0;
	int unsigned reports_checked = 0;
	int unsigned report_errors = 0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;         // no idling on either side once set

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void start_frame();
		frame_len  = '0;
		sirc_alive = 1'b1;
		sirc_word  = '0;
		rc5_alive  = 1'b1;
		rc5_halves = 7'd1;
		rc5_word   = '0;
	endfunction

	// SIRC start mark and spaces use a closed window of nominal +/- nominal/5.
	function automatic bit within_closed(int unsigned d, int unsigned nom);
		return d <= nom + nom / 5 && d >= nom - nom / 5;
	endfunction

	// Bit marks and every RC5 duration use the open window.
	function automatic bit within_open(int unsigned d, int unsigned nom);
		return d > nom - nom / 5 && d < nom + nom / 5;
	endfunction

	// Advance the frame state by one accepted transaction and queue any report it causes.
	function automatic void decode_item(irsr_pkg::item_t it);
		int unsigned d, n, pos, halves;
		irsr_pkg::result_t rep;
		bit          emits;
		d     = 32'(it.duration);
		n     = 32'(frame_len);
		rep   = '0;
		emits = 1'b0;
		if (it.func == irsr_pkg::FUNC_DURATION) begin
			if (sirc_alive) begin
				if (n == 0)
					sirc_alive = within_closed(d, 32'(timing[irsr_pkg::REG_SIRC_START]));
				else if (n[0])
					sirc_alive = within_closed(d, 32'(timing[irsr_pkg::REG_SIRC_SPACE]));
				else if (within_open(d, 32'(timing[irsr_pkg::REG_SIRC_ONE]))) begin
					// marks beyond bit 11 leave no trace
					if ((n - 2) / 2 < irsr_pkg::SIRC_BITS_W)
						sirc_word[(n - 2) / 2] = 1'b1;
				end else
					sirc_alive = within_open(d, 32'(timing[irsr_pkg::REG_SIRC_ZERO]));
			end
			if (rc5_alive) begin
				halves = 32'(rc5_halves);
				pos    = halves >> 1;
				// a mark that starts mid-bit carries a one; positions past bit 0 are dropped
				if (halves[0] && !n[0] && pos <= 13)
					rc5_word[13 - pos] = 1'b1;
				if (within_open(d, 32'(timing[irsr_pkg::REG_RC5_HALF])))
					halves += 1;
				else if (within_open(d, 32'(timing[irsr_pkg::REG_RC5_FULL])))
					halves += 2;
				else
					rc5_alive = 1'b0;
				rc5_halves = (halves > 127) ? 7'd127 : halves[6:0];
			end
			frame_len = 7'(n + 1);
			if (frame_len >= irsr_pkg::MAX_DURATIONS_DEF - 1) begin
				rep.status = irsr_pkg::ST_TOO_MANY;
				emits      = 1'b1;
			end
		end else if (it.func == irsr_pkg::FUNC_TIMEOUT) begin
			rep.status = irsr_pkg::ST_TIMEOUT;
			emits      = 1'b1;
		end else if (it.func == irsr_pkg::FUNC_END) begin
			// SIRC wins over RC5 when both still hold
			if (sirc_alive && frame_len == irsr_pkg::SIRC_FRAME_LEN) begin
				rep.status      = irsr_pkg::ST_OK;
				rep.protocol    = irsr_pkg::PROTO_SIRC;
				rep.address     = sirc_word[11:7];
				rep.command     = sirc_word[6:0];
				rep.repeat_time = timing[irsr_pkg::REG_SIRC_REPEAT];
			end else if (rc5_alive) begin
				rep.status      = irsr_pkg::ST_OK;
				rep.protocol    = irsr_pkg::PROTO_RC5;
				rep.address     = rc5_word[10:6];
				rep.command     = {~rc5_word[12], rc5_word[5:0]};
				rep.repeat_time = timing[irsr_pkg::REG_RC5_REPEAT];
			end else
				rep.status = irsr_pkg::ST_NO_PROTO;
			emits = 1'b1;
		end
		if (emits) begin
			frame_reports.push_back(rep);
			reports_due++;
			start_frame();
		end
	endfunction

	// ------------------------------------------------------------------
	// Duration generators
	// ------------------------------------------------------------------

	function automatic int unsigned clamp16(int v);
		return v < 0 ? 0 : (v > 65535 ? 65535 : v);
	endfunction

	// Land just inside or just outside a window, on a random side of the nominal.
	function automatic int unsigned edge_of(int unsigned nom, bit open_win, bit outside);
		int off;
		off = nom / 5;
		if (open_win)
			off = outside ? off : off - 1;
		else
			off = outside ? off + 1 : off;
		return clamp16($urandom_range(0, 1) ? int'(nom) + off : int'(nom) - off);
	endfunction

	// Mostly mild jitter, sometimes coarse, sometimes right on a window limit.
	function automatic int unsigned wobble(int unsigned nom);
		int span;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick >= 17)
			return edge_of(nom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		span = (pick < 14) ? nom / 10 : (nom * 3) / 10;
		return clamp16(int'(nom) - span + int'($urandom_range(0, 2 * span)));
	endfunction

	function automatic logic [15:0] noise_duration();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 65535));
			1: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			default: return 16'(wobble(32'(timing[4'($urandom_range(0, 5))])));
		endcase
	endfunction

	function automatic timing_style_t pick_style();
		case ($urandom_range(0, 9))
			0: return TIMING_EDGE_IN;
			1: return TIMING_EDGE_OUT;
			default: return TIMING_WOBBLE;
		endcase
	endfunction

	// RC5 frames start with a one almost always, so the leading space is skipped.
	function automatic logic [13:0] rc5_code();
		logic [13:0] word;
		word = 14'($urandom);
		if ($urandom_range(0, 7) != 0)
			word[13] = 1'b1;
		return word;
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	// Offer one transaction at a falling edge and hold it until taken. On return the
	// clock is at a falling edge and item_valid is still high: the caller either sends
	// again or drops valid, so valid gets one assignment per edge.
	task automatic send_item(input logic [1:0] func, input logic [15:0] duration);
		irsr_pkg::item_t it;
		it.func     = func;
		it.duration = duration;
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		decode_item(it);
		if (func != FUNC_UNUSED)
			items_fed++;
		@(negedge clk);
	endtask

	// Drop valid, hold until every owed report has arrived, then let the pipe settle.
	task automatic wait_for_reports();
		item_valid <= 1'b0;
		while (frame_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all sixteen indexes; those past seven carry random data and must be dropped.
	task automatic load_timing(input irsr_pkg::cfg_t c);
		int          idx;
		logic [15:0] data;
		for (idx = 0; idx < 16; idx++) begin
			case (idx[irsr_pkg::CFG_INDEX_W-1:0])
				irsr_pkg::REG_SIRC_START:  data = c.sirc_start_time;
				irsr_pkg::REG_SIRC_SPACE:  data = c.sirc_space_time;
				irsr_pkg::REG_SIRC_ONE:    data = c.sirc_one_time;
				irsr_pkg::REG_SIRC_ZERO:   data = c.sirc_zero_time;
				irsr_pkg::REG_RC5_HALF:    data = c.rc5_half_time;
				irsr_pkg::REG_RC5_FULL:    data = c.rc5_full_time;
				irsr_pkg::REG_SIRC_REPEAT: data = c.sirc_repeat_ms;
				irsr_pkg::REG_RC5_REPEAT:  data = c.rc5_repeat_ms;
				default:                   data = 16'($urandom_range(0, 65535));
			endcase
			cfg_index <= idx[irsr_pkg::CFG_INDEX_W-1:0];
			cfg_data  <= data;
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg_ready);
			if (idx < 8)
				timing[idx[irsr_pkg::CFG_INDEX_W-1:0]] = data;
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// SIRC: start mark, then twelve space/mark pairs, bit 0 first; keep trims the frame.
	task automatic send_sirc_frame(input logic [11:0] code, input timing_style_t style,
		input int unsigned keep);
		int unsigned slot, bad_slot, nom, d;
		bit          open_win;
		bad_slot = $urandom_range(0, 24);
		for (slot = 0; slot < 25 && slot < keep; slot++) begin
			if (slot == 0) begin
				nom      = 32'(timing[irsr_pkg::REG_SIRC_START]);
				open_win = 1'b0;
			end else if (slot % 2) begin
				nom      = 32'(timing[irsr_pkg::REG_SIRC_SPACE]);
				open_win = 1'b0;
			end else begin
				nom      = code[(slot - 2) / 2] ? 32'(timing[irsr_pkg::REG_SIRC_ONE]) :
					32'(timing[irsr_pkg::REG_SIRC_ZERO]);
				open_win = 1'b1;
			end
			case (style)
				TIMING_WOBBLE:  d = wobble(nom);
				TIMING_EDGE_IN: d = edge_of(nom, open_win, 1'b0);
				default:        d = edge_of(nom, open_win, slot == bad_slot);
			endcase
			send_item(irsr_pkg::FUNC_DURATION, d[15:0]);
		end
	endtask

	// RC5: Manchester halves (one is space then mark), merged into runs of marks and
	// spaces; the idle space before the first mark and after the last is not measured.
	task automatic send_rc5_frame(input logic [13:0] word, input timing_style_t style,
		input int unsigned keep);
		logic [27:0] level;
		int          k, run, sent, bad;
		int unsigned nom, d;
		for (k = 0; k < 14; k++) begin
			level[2 * k]     = !word[13 - k];
			level[2 * k + 1] = word[13 - k];
		end
		bad  = $urandom_range(0, 13);
		k    = 0;
		run  = 0;
		sent = 0;
		while (k < 28 && !level[k])
			k++;
		while (k < 28 && sent < keep) begin
			run++;
			if (k == 27 || level[k + 1] != level[k]) begin
				if (level[k] || k != 27) begin
					nom = (run == 1) ? 32'(timing[irsr_pkg::REG_RC5_HALF]) :
						32'(timing[irsr_pkg::REG_RC5_FULL]);
					case (style)
						TIMING_WOBBLE:  d = wobble(nom);
						TIMING_EDGE_IN: d = edge_of(nom, 1'b1, 1'b0);
						default:        d = edge_of(nom, 1'b1, sent == bad);
					endcase
					send_item(irsr_pkg::FUNC_DURATION, d[15:0]);
					sent++;
				end
				run = 0;
			end
			k++;
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver and checking
	// ------------------------------------------------------------------

	// Stall the result channel at random, never once calm.
	always @(negedge clk) begin
		if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 5);
		if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else
			result_ready <= 1'b1;
	end

	// Compare every report taken off the result channel with the oldest one owed.
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (frame_reports.size() == 0) begin
				if (report_errors < REPORT_LIMIT)
					$display("%0t: report with none owed: st=%0d pr=%0d addr=%0d cmd=%0h rep=%0d",
						$realtime, result.status, result.protocol, result.address,
						result.command, result.repeat_time);
				report_errors++;
			end else begin
				oldest = frame_reports.pop_front();
				if (result.status !== oldest.status || result.protocol !== oldest.protocol ||
					result.address !== oldest.address || result.command !== oldest.command ||
					result.repeat_time !== oldest.repeat_time) begin
					if (report_errors < REPORT_LIMIT) begin
						$display("%0t: report %0d expected st=%0d pr=%0d addr=%0d cmd=%0h rep=%0d",
							$realtime, reports_checked, oldest.status, oldest.protocol,
							oldest.address, oldest.command, oldest.repeat_time);
						$display("%0t: report %0d actual   st=%0d pr=%0d addr=%0d cmd=%0h rep=%0d",
							$realtime, reports_checked, result.status, result.protocol,
							result.address, result.command, result.repeat_time);
					end
					report_errors++;
				end
			end
			reports_checked++;
		end
	end

	// Hard stop in case the decoder hangs or loses a report.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ir_sirc_rc5_frame_decoder_unit: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty and one- or two-duration frames, field extremes, mark timeouts and the unused code.
	task automatic test_short_frames();
		send_item(irsr_pkg::FUNC_END, 16'h0000);       // empty frame reads as RC5, command 0x40
		send_item(FUNC_UNUSED, 16'hffff);              // dropped, no report
		send_item(irsr_pkg::FUNC_TIMEOUT, 16'haaaa);
		send_item(irsr_pkg::FUNC_DURATION, 16'h0000);
		send_item(irsr_pkg::FUNC_END, 16'h5555);       // nothing matches
		send_item(irsr_pkg::FUNC_DURATION, 16'hffff);
		send_item(irsr_pkg::FUNC_END, 16'hffff);
		send_item(irsr_pkg::FUNC_DURATION, 16'd889);   // one half-bit mark: start bit only
		send_item(FUNC_UNUSED, 16'h5555);
		send_item(irsr_pkg::FUNC_END, 16'h0000);
		send_item(irsr_pkg::FUNC_DURATION, 16'd1778);
		send_item(irsr_pkg::FUNC_DURATION, 16'd889);
		send_item(irsr_pkg::FUNC_TIMEOUT, 16'h0000);   // timeout mid-frame
		send_item(irsr_pkg::FUNC_DURATION, 16'd1920);  // SIRC start on its lower limit
		send_item(irsr_pkg::FUNC_DURATION, 16'd480);
		send_item(irsr_pkg::FUNC_TIMEOUT, 16'hffff);
	endtask

	// Whole frames with every duration just inside its window, then with one just past it.
	task automatic test_window_edges();
		send_sirc_frame(12'ha5c, TIMING_EDGE_IN, 25);
		send_item(irsr_pkg::FUNC_END, 16'h0000);
		send_sirc_frame(12'h3c3, TIMING_EDGE_OUT, 25);
		send_item(irsr_pkg::FUNC_END, 16'h0000);
		send_rc5_frame(rc5_code(), TIMING_EDGE_IN, 28);
		send_item(irsr_pkg::FUNC_END, 16'h0000);
		send_rc5_frame(rc5_code(), TIMING_EDGE_OUT, 28);
		send_item(irsr_pkg::FUNC_END, 16'h0000);
	endtask

	// One duration short of the limit still evaluates; the next frame overflows.
	task automatic test_overlong_frame();
		int k;
		for (k = 0; k < irsr_pkg::MAX_DURATIONS_DEF - 2; k++)
			send_item(irsr_pkg::FUNC_DURATION,
				16'(wobble(32'(timing[irsr_pkg::REG_RC5_FULL]))));
		send_item(irsr_pkg::FUNC_END, 16'h0000);
		for (k = 0; k < irsr_pkg::MAX_DURATIONS_DEF - 1; k++)
			send_item(irsr_pkg::FUNC_DURATION, 16'(wobble(32'(timing[$urandom_range(0, 1) ?
				irsr_pkg::REG_RC5_HALF : irsr_pkg::REG_RC5_FULL]))));
		send_item(irsr_pkg::FUNC_END, 16'h0000);
	endtask

	// Mostly well-formed frames with random content, the rest damaged or noise.
	task automatic test_random_frames(input int unsigned item_goal,
		input int unsigned report_goal);
		int unsigned first_item, first_report, k;
		bit          paused;
		first_item   = items_fed;
		first_report = reports_due;
		paused       = 1'b0;
		while (items_fed - first_item < item_goal ||
			reports_due - first_report < report_goal) begin
			// hold off once half way until the decoder has caught up
			if (!paused && items_fed - first_item >= item_goal / 2) begin
				wait_for_reports();
				paused = 1'b1;
			end
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: begin
					send_sirc_frame(12'($urandom), pick_style(), 25);
					send_item(irsr_pkg::FUNC_END, 16'($urandom));
				end
				7, 8, 9, 10, 11, 12: begin
					send_rc5_frame(rc5_code(), pick_style(), 28);
					send_item(irsr_pkg::FUNC_END, 16'($urandom));
				end
				13: begin
					send_sirc_frame(12'($urandom), TIMING_WOBBLE, $urandom_range(1, 24));
					send_item(irsr_pkg::FUNC_END, 16'($urandom));
				end
				14: begin
					send_rc5_frame(rc5_code(), TIMING_WOBBLE, $urandom_range(1, 12));
					send_item(irsr_pkg::FUNC_TIMEOUT, 16'($urandom));
				end
				15: begin
					send_sirc_frame(12'($urandom), TIMING_WOBBLE, 25);
					send_item(irsr_pkg::FUNC_TIMEOUT, 16'($urandom));
				end
				16: begin
					send_sirc_frame(12'($urandom), TIMING_WOBBLE, 25);
					repeat ($urandom_range(1, 2))
						send_item(irsr_pkg::FUNC_DURATION, noise_duration());
					send_item(irsr_pkg::FUNC_END, 16'($urandom));
				end
				17: begin
					repeat ($urandom_range(0, 8))
						send_item(irsr_pkg::FUNC_DURATION, noise_duration());
					send_item(irsr_pkg::FUNC_END, 16'($urandom));
				end
				18: repeat ($urandom_range(1, 3)) send_item(FUNC_UNUSED, 16'($urandom));
				default: begin
					// the overflow report ends the frame by itself
					for (k = 0; k < irsr_pkg::MAX_DURATIONS_DEF - 1; k++)
						send_item(irsr_pkg::FUNC_DURATION, $urandom_range(0, 3) == 0 ?
							noise_duration() : 16'(wobble(32'(timing[$urandom_range(0, 1) ?
							irsr_pkg::REG_RC5_HALF : irsr_pkg::REG_RC5_FULL]))));
				end
			endcase
		end
	endtask

	// Every register at zero or full scale, in two opposite patterns.
	task automatic test_timing_extremes();
		irsr_pkg::cfg_t c;
		wait_for_reports();
		c = '{sirc_start_time: 16'hffff, sirc_space_time: 16'h0000,
			sirc_one_time: 16'hffff, sirc_zero_time: 16'h0000,
			rc5_half_time: 16'h0000, rc5_full_time: 16'hffff,
			sirc_repeat_ms: 16'hffff, rc5_repeat_ms: 16'h0000};
		load_timing(c);
		test_random_frames(15, 2);
		wait_for_reports();
		load_timing(~c);
		test_random_frames(15, 2);
	endtask

	// SIRC and RC5 timings each stretched by their own random factor.
	task automatic test_scaled_timing();
		irsr_pkg::cfg_t c;
		int unsigned f, g;
		wait_for_reports();
		f = $urandom_range(40, 250);
		g = $urandom_range(40, 250);
		c.sirc_start_time = 16'(32'(irsr_pkg::RST_SIRC_START) * f / 100);
		c.sirc_space_time = 16'(32'(irsr_pkg::RST_SIRC_SPACE) * f / 100);
		c.sirc_one_time   = 16'(32'(irsr_pkg::RST_SIRC_ONE) * f / 100);
		c.sirc_zero_time  = 16'(32'(irsr_pkg::RST_SIRC_ZERO) * f / 100);
		c.rc5_half_time   = 16'(32'(irsr_pkg::RST_RC5_HALF) * g / 100);
		c.rc5_full_time   = 16'(32'(irsr_pkg::RST_RC5_FULL) * g / 100);
		c.sirc_repeat_ms  = 16'($urandom_range(0, 65535));
		c.rc5_repeat_ms   = 16'($urandom_range(0, 65535));
		load_timing(c);
		test_random_frames(60, 6);
	endtask

	// Back to the reset timings with both channels running flat out.
	task automatic test_settled_run();
		irsr_pkg::cfg_t c;
		wait_for_reports();
		c = '{sirc_start_time: irsr_pkg::RST_SIRC_START,
			sirc_space_time: irsr_pkg::RST_SIRC_SPACE,
			sirc_one_time: irsr_pkg::RST_SIRC_ONE,
			sirc_zero_time: irsr_pkg::RST_SIRC_ZERO,
			rc5_half_time: irsr_pkg::RST_RC5_HALF,
			rc5_full_time: irsr_pkg::RST_RC5_FULL,
			sirc_repeat_ms: irsr_pkg::RST_SIRC_REPEAT,
			rc5_repeat_ms: irsr_pkg::RST_RC5_REPEAT};
		load_timing(c);
		calm = 1'b1;
		test_random_frames(30, 3);
	endtask

	initial begin
		timing[irsr_pkg::REG_SIRC_START]  = irsr_pkg::RST_SIRC_START;
		timing[irsr_pkg::REG_SIRC_SPACE]  = irsr_pkg::RST_SIRC_SPACE;
		timing[irsr_pkg::REG_SIRC_ONE]    = irsr_pkg::RST_SIRC_ONE;
		timing[irsr_pkg::REG_SIRC_ZERO]   = irsr_pkg::RST_SIRC_ZERO;
		timing[irsr_pkg::REG_RC5_HALF]    = irsr_pkg::RST_RC5_HALF;
		timing[irsr_pkg::REG_RC5_FULL]    = irsr_pkg::RST_RC5_FULL;
		timing[irsr_pkg::REG_SIRC_REPEAT] = irsr_pkg::RST_SIRC_REPEAT;
		timing[irsr_pkg::REG_RC5_REPEAT]  = irsr_pkg::RST_RC5_REPEAT;
		start_frame();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_short_frames();
		test_window_edges();
		test_overlong_frame();
		test_timing_extremes();
		test_scaled_timing();
		test_settled_run();

		// drain, give the pipe time to show any stray report, then judge
		wait_for_reports();
		if (report_errors == 0 && frame_reports.size() == 0)
			$display("ir_sirc_rc5_frame_decoder_unit: match");
		else
			$display("ir_sirc_rc5_frame_decoder_unit: mismatch");
		$finish;
	end

endmodule
